[sv/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the Base64 stream decoder
// Character classification, status codes and the group record that the
// front part hands to the back part through the queue.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  localparam logic [1:0] POS_LAST = 2'd3;

  typedef struct packed {
    logic [5:0] value;
    logic       bad;
    logic       pad;
  } sextet_t;

  // One decoded group: up to three bytes, most significant first
  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  count;
    logic [1:0]  status;
    logic        last;
  } group_t;

  function automatic sextet_t classify(input logic [7:0] c);
    sextet_t s;
    s.value = 6'd0;
    s.bad   = 1'b0;
    s.pad   = 1'b0;
    if (c inside {[8'h41:8'h5A]}) begin
      s.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == PLUS_CHAR) begin
      s.value = 6'd62;
    end else if (c == SLASH_CHAR) begin
      s.value = 6'd63;
    end else if (c == PAD_CHAR) begin
      s.pad = 1'b1;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

[sv/b64d_front.sv]
// ----------------------------------------------------------------------------
// b64d_front: character intake and group assembly
// Classifies each character, gathers sextets into groups and pushes one
// group record per completed group or truncated text.
// ----------------------------------------------------------------------------
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  input  logic       accept,
  output logic       push,
  output group_t     push_data
);

  logic [17:0] acc;
  logic [1:0]  pos;
  logic        third_pad;
  logic        err;

  sextet_t     sx;
  logic        err_now;
  logic [1:0]  count_final;

  always_comb begin
    sx          = classify(char_code);
    err_now     = err | sx.bad;
    count_final = 2'd3 - {1'b0, third_pad} - {1'b0, sx.pad};
    push        = accept && ((pos == POS_LAST) || end_of_text);
    if (pos == POS_LAST) begin
      push_data.triple = {acc, sx.value};
      push_data.count  = end_of_text ? count_final : 2'd3;
      push_data.status = err_now ? ST_BAD : ST_OK;
      push_data.last   = end_of_text;
    end else begin
      push_data.triple = 24'd0;
      push_data.count  = 2'd1;
      push_data.status = err_now ? ST_BAD : ST_TRUNC;
      push_data.last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 18'd0;
      pos       <= 2'd0;
      third_pad <= 1'b0;
      err       <= 1'b0;
    end else if (accept) begin
      if (end_of_text || pos == POS_LAST) begin
        acc       <= 18'd0;
        pos       <= 2'd0;
        third_pad <= 1'b0;
        err       <= end_of_text ? 1'b0 : err_now;
      end else begin
        case (pos)
          2'd0: acc <= {sx.value, 12'd0};
          2'd1: acc <= {acc[17:12], sx.value, 6'd0};
          2'd2: begin
            acc       <= {acc[17:6], sx.value};
            third_pad <= sx.pad;
          end
          default: acc <= acc;
        endcase
        pos <= pos + 2'd1;
        err <= err_now;
      end
    end
  end

endmodule

[sv/b64d_fifo.sv]
// ----------------------------------------------------------------------------
// b64d_fifo: short group queue
// Decouples group assembly from byte output so either side can stall.
// ----------------------------------------------------------------------------
module b64d_fifo
  import b64d_pkg::*;
#(
  parameter int DEPTH = 4
)
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t push_data,
  input  logic   pop,
  output group_t head,
  output logic   head_valid,
  output logic   full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  group_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [LW-1:0] level;

  assign full       = (level == LW'(DEPTH));
  assign head_valid = (level != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + LW'(1);
        2'b01:   level <= level - LW'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

[sv/b64d_back.sv]
// ----------------------------------------------------------------------------
// b64d_back: byte serialiser and output register
// Emits head group bytes into a registered stream, one per cycle while ready.
// ----------------------------------------------------------------------------
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  group_t     head,
  input  logic       head_valid,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // data_byte
  output logic [1:0] m_tuser,   // status
  output logic       m_tlast    // last_byte
);

  logic [1:0] idx;
  logic       load;
  logic       final_byte;
  logic [7:0] byte_sel;

  always_comb begin
    load       = head_valid && (!m_tvalid || m_tready);
    final_byte = ((idx + 2'd1) == head.count);
    pop        = load && final_byte;
    case (idx)
      2'd0:    byte_sel = head.triple[23:16];
      2'd1:    byte_sel = head.triple[15:8];
      default: byte_sel = head.triple[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= byte_sel;
      m_tuser <= head.status;
      m_tlast <= head.last && final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= final_byte ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[sv/base64_stream_decoder.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming Base64 text decoder
// Input: s_tdata carries one ASCII character, s_tlast marks the final
// character of a text. Output: m_tdata carries one decoded byte, m_tuser the
// status (0 ok, 1 invalid character seen in this text, 2 text length not a
// multiple of four), m_tlast the final result of the text.
// A completed group of four characters yields three bytes (fewer when the
// final group holds padding); a text ending mid-group yields one status
// result with a zero byte.
// The closing character of a group writes the group record into the queue;
// its first byte enters the output register once that is free, and the
// other bytes follow one per cycle while m_tready is high. Throughput: one
// character per cycle while the queue is not full, one byte per cycle; the
// byte serialiser sets the output rate, and the group queue absorbs bursts.
// When the receiver stalls, the output register holds and the queue fills;
// s_tready drops only once the queue is full.
// Reset (rst, synchronous) clears the group state, the queue and the output
// valid flag; s_tready is low during reset and the block accepts characters
// in the first cycle after reset.
// ----------------------------------------------------------------------------
module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // char_code
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // data_byte
  output logic [1:0] m_tuser,   // status
  output logic       m_tlast    // last_byte
);

  logic   accept;
  logic   push;
  group_t push_data;
  logic   pop;
  group_t head;
  logic   head_valid;
  logic   full;

  assign s_tready = !full && !rst;
  assign accept   = s_tvalid && s_tready;

  b64d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .char_code   (s_tdata),
    .end_of_text (s_tlast),
    .accept      (accept),
    .push        (push),
    .push_data   (push_data)
  );

  b64d_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("group pushed into full queue");

  a_head_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> head.count != 2'd0)
    else $error("queued group with no bytes");

  a_trunc_is_final: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_TRUNC) |-> (m_tlast && m_tdata == 8'd0))
    else $error("truncation status on a non-final or non-zero result");

  a_pop_only_on_output_load: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_tvalid)
    else $error("group retired without a result on the output");

endmodule

[verif/tb_base64_stream_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder: self-checking bench for the Base64 stream decoder
// Feeds texts one character per transaction and predicts every decoded byte
// and status in a scoreboard that tracks the group state of the current text.
// A short directed set covers the alphabet edges, padding in the first, third
// and fourth positions, invalid characters and truncated texts. Random texts
// follow: mostly well-formed with random content, the rest truncated or
// corrupted. Both sides stall at random, with one long receiver hold-off
// that backs up the input and two pauses until all expected results have come.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder;
  import b64d_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam int IDLE_LIMIT   = 2000;
  localparam int CHAR_TARGET  = 180;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } byte_result_t;

  class decode_scoreboard;
    byte_result_t expected_bytes[$];
    logic [17:0]  acc;
    logic [1:0]   pos;
    logic         third_pad;
    logic         err_seen;
    int mismatches, checked, texts, bad_results, trunc_results;

    function new();
      clear_text();
      err_seen      = 1'b0;
      mismatches    = 0;
      checked       = 0;
      texts         = 0;
      bad_results   = 0;
      trunc_results = 0;
    endfunction

    function void clear_text();
      acc       = '0;
      pos       = '0;
      third_pad = 1'b0;
    endfunction

    function logic [5:0] sextet(input logic [7:0] c, output logic bad);
      bad = 1'b0;
      if (c >= "A" && c <= "Z") return 6'(c - "A");
      if (c >= "a" && c <= "z") return 6'(c - "a" + 26);
      if (c >= "0" && c <= "9") return 6'(c - "0" + 52);
      if (c == PLUS_CHAR) return 6'd62;
      if (c == SLASH_CHAR) return 6'd63;
      if (c != PAD_CHAR) bad = 1'b1;
      return 6'd0;
    endfunction

    function void push_result(input logic [7:0] d, input logic [1:0] st, input logic last);
      byte_result_t r;
      r.data   = d;
      r.status = st;
      r.last   = last;
      expected_bytes.push_back(r);
      if (st == ST_BAD) bad_results++;
      if (st == ST_TRUNC) trunc_results++;
    endfunction

    function void note_char(input logic [7:0] c, input logic eot);
      logic [5:0]  v;
      logic        bad;
      logic [23:0] triple;
      logic [1:0]  st;
      int          count;
      int          i;
      v = sextet(c, bad);
      if (bad) err_seen = 1'b1;
      if (pos != POS_LAST) begin
        case (pos)
          2'd0: acc = {v, 12'd0};
          2'd1: acc[11:6] = v;
          default: begin
            acc[5:0]  = v;
            third_pad = (c == PAD_CHAR);
          end
        endcase
        pos = pos + 2'd1;
        if (eot) begin
          push_result(8'd0, err_seen ? ST_BAD : ST_TRUNC, 1'b1);
          clear_text();
          err_seen = 1'b0;
          texts++;
        end
      end else begin
        triple = {acc, v};
        st     = err_seen ? ST_BAD : ST_OK;
        count  = 3;
        if (eot) count = count - int'(third_pad) - int'(c == PAD_CHAR);
        for (i = 0; i < count; i++) begin
          push_result(triple[23 - 8 * i -: 8], st, eot && (i == count - 1));
        end
        clear_text();
        if (eot) begin
          err_seen = 1'b0;
          texts++;
        end
      end
    endfunction

    function void check_result(input logic [7:0] d, input logic [1:0] st, input logic last);
      byte_result_t want;
      checked++;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result data=%h status=%0d last=%0b", $time, d, st, last);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (d !== want.data || st !== want.status || last !== want.last) begin
          $display("%0t: mismatch expected data=%h status=%0d last=%0b,",
                   $time, want.data, want.status, want.last);
          $display("%0t:          got data=%h status=%0d last=%0b",
                   $time, d, st, last);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'd0;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  decode_scoreboard board;
  logic [7:0] text_buf[$];
  int  chars_sent  = 0;
  int  idle_cycles = 0;
  bit  calm        = 1'b0;
  bit  hold_req    = 1'b0;
  bit  holding     = 1'b0;

  base64_stream_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] alphabet_char(input int idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    if (idx == 62) return PLUS_CHAR;
    return SLASH_CHAR;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eot);
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eot;
    do @(posedge clk); while (!s_tready);
    board.note_char(c, eot);
    chars_sent++;
  endtask

  task automatic send_text(input bit burst);
    int i;
    int gap;
    for (i = 0; i < text_buf.size(); i++) begin
      send_char(text_buf[i], i == text_buf.size() - 1);
      gap = (burst || calm) ? 0 : gap_len();
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    text_buf.delete();
  endtask

  task automatic load_string(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_text();
    int groups;
    int shape;
    int spot;
    int i;
    groups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    for (i = 0; i < groups * 4; i++) text_buf.push_back(alphabet_char($urandom_range(0, 63)));
    shape = $urandom_range(0, 9);
    if (shape < 3) begin
      // trailing pads in the final group, or a pad in its third place only
      case ($urandom_range(0, 2))
        0: text_buf[$] = PAD_CHAR;
        1: begin
          text_buf[$]   = PAD_CHAR;
          text_buf[$-1] = PAD_CHAR;
        end
        default: text_buf[$-1] = PAD_CHAR;
      endcase
    end else if (shape < 5) begin
      repeat ($urandom_range(1, 3)) void'(text_buf.pop_back());
    end else if (shape < 7) begin
      repeat ($urandom_range(1, 2)) begin
        spot = $urandom_range(0, text_buf.size() - 1);
        text_buf[spot] = $urandom_range(0, 1) ? PAD_CHAR : 8'($urandom_range(0, 255));
      end
    end
    send_text(1'b0);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready && board != null) begin
      board.check_result(m_tdata, m_tuser, m_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_base64_stream_decoder NOT OK");
      $finish;
    end
  end

  initial begin
    int stall;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = gap_len();
        if (stall == 0) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int i;
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    load_string("=AZaz09+/QA=");
    send_text(1'b0);
    load_string("xy=z");
    send_text(1'b0);
    load_string("TQ==");
    send_text(1'b0);
    text_buf = '{8'h00, "B", "C", 8'hFF, "A"};
    send_text(1'b0);
    load_string("AB");
    send_text(1'b0);

    // hold the sender until everything is out, then back up the input
    drain();
    hold_req = 1'b1;
    wait (holding);
    for (i = 0; i < 40; i++) text_buf.push_back(alphabet_char($urandom_range(0, 63)));
    send_text(1'b1);

    while (chars_sent < CHAR_TARGET) begin
      calm = ($urandom_range(0, 5) == 0);
      random_text();
    end
    calm = 1'b0;
    drain();

    $display("Decoded %0d characters in %0d texts: %0d results checked,",
             chars_sent, board.texts, board.checked);
    $display("%0d with invalid status, %0d truncated.",
             board.bad_results, board.trunc_results);
    if (board.mismatches == 0 && board.expected_bytes.size() == 0) begin
      $display("tb_base64_stream_decoder OK");
    end else begin
      $display("tb_base64_stream_decoder NOT OK");
    end
    $finish;
  end

endmodule
